// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the solver checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/jls_pkg.sv =====
// ----------------------------------------------------------------------------
// jls_pkg
// Types and constants shared by the Jacobi solver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package jls_pkg;

  localparam int MAX_N_DEF = 64;

  localparam logic [1:0] CMD_MAT   = 2'd0;
  localparam logic [1:0] CMD_RHS   = 2'd1;
  localparam logic [1:0] CMD_SOLVE = 2'd2;

  localparam logic [1:0] CFG_SIZE = 2'd0;
  localparam logic [1:0] CFG_TOL  = 2'd1;
  localparam logic [1:0] CFG_ITER = 2'd2;

  localparam logic [6:0]  SIZE_RST = 7'd64;
  localparam logic [30:0] TOL_RST  = 31'd66;
  localparam logic [15:0] ITER_RST = 16'd1000;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DIV,
    ST_WRITE,
    ST_SWEEP,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

  typedef struct packed {
    logic              done;
    logic              zero_den;
    logic signed [31:0] quot;
  } div_res_t;

endpackage

`default_nettype wire

// ===== design/jls_divider.sv =====
// ----------------------------------------------------------------------------
// jls_divider
// Serial signed Q16.16 divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
`default_nettype none

module jls_divider #(
  parameter int NUM_W = 41
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [31:0]      den,
  output jls_pkg::div_res_t       res
);

  localparam int DV_W = NUM_W + 16;
  localparam int CW   = $clog2(DV_W + 1);

  logic              busy;
  logic              fin;
  logic              done;
  logic              zero_den;
  logic [CW-1:0]     cnt;
  logic [DV_W-1:0]   dv;
  logic [31:0]       dsr;
  logic [31:0]       rem;
  logic              neg;
  logic signed [31:0] quot;

  logic [NUM_W-1:0]  num_mag;
  logic [31:0]       den_mag;
  logic [32:0]       shifted;
  logic [33:0]       trial;
  logic [31:0]       rem_next;
  logic              qbit;
  logic signed [31:0] sat_q;

  always_comb begin
    num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    den_mag  = den[31] ? 32'(-den) : 32'(den);
    shifted  = {rem, dv[DV_W-1]};
    trial    = {1'b0, shifted} - {2'b00, dsr};
    qbit     = ~trial[33];
    rem_next = qbit ? trial[31:0] : shifted[31:0];
    if (neg) begin
      if (dv > DV_W'(33'h1_0000_0000 >> 1)) begin
        sat_q = jls_pkg::Q_MIN;
      end else begin
        sat_q = 32'sd0 - $signed(dv[31:0]);
      end
    end else begin
      if (dv > DV_W'(32'h7FFF_FFFF)) begin
        sat_q = jls_pkg::Q_MAX;
      end else begin
        sat_q = $signed(dv[31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den == 32'sd0) begin
          zero_den <= 1'b1;
          done     <= 1'b1;
          if (num == '0) begin
            quot <= 32'sd0;
          end else if (num[NUM_W-1]) begin
            quot <= jls_pkg::Q_MIN;
          end else begin
            quot <= jls_pkg::Q_MAX;
          end
        end else begin
          zero_den <= 1'b0;
          busy     <= 1'b1;
          cnt      <= CW'(DV_W);
          dv       <= {num_mag, 16'h0000};
          dsr      <= den_mag;
          rem      <= 32'd0;
          neg      <= num[NUM_W-1] ^ den[31];
        end
      end else if (busy) begin
        rem <= rem_next;
        dv  <= {dv[DV_W-2:0], qbit};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        quot <= sat_q;
        done <= 1'b1;
      end
    end
  end

  assign res.done     = done;
  assign res.zero_den = zero_den;
  assign res.quot     = quot;

endmodule

`default_nettype wire

// ===== design/jacobi_linear_solver.sv =====
// Load items: one per cycle while in_stall is low (idle only), no result. Solve:
// each sweep works row by row through the serial multiply-accumulate over the
// matrix memory and the one-bit-per-cycle divider (NUM_W = 34 + log2 MAX_N).
// Results then leave one at a time, each first read from the guess memory.
// Reset is synchronous; it clears control and configuration, not the memories.
// ----------------------------------------------------------------------------
// jacobi_linear_solver
// Jacobi iterative solver in Q16.16 with matrix, rhs and guess memories.
// ----------------------------------------------------------------------------
`default_nettype none

module jacobi_linear_solver #(
  parameter int MAX_N = jls_pkg::MAX_N_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [5:0]         row,
  input  logic [5:0]         col,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         index,
  output logic signed [31:0] solution,
  output logic               converged,
  output logic [15:0]        iterations_used,
  output logic               zero_pivot,
  output logic               last
);

  localparam int IW    = $clog2(MAX_N);
  localparam int AW    = $clog2(MAX_N * MAX_N);
  localparam int ACC_W = 33 + IW;
  localparam int NUM_W = ACC_W + 1;
  localparam logic signed [63:0] P_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] P_MIN = 64'shFFFF_FFFF_8000_0000;

  jls_pkg::state_t state, state_next;

  logic [6:0]  size_in_use;
  logic [30:0] tolerance;
  logic [15:0] max_iterations;

  logic [IW-1:0] i_cnt, j_cnt, n_m1, n_m1_new;
  logic          bank;
  logic          first;
  logic          s1_v, s1_diag, s2_v;
  logic signed [31:0] diag, prev_i, x_reg;
  logic signed [63:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic [32:0]   change_max;
  logic [15:0]   sweep_count, left;
  logic          zero_flag;
  logic          conv;

  logic signed [31:0] mat_mem [MAX_N*MAX_N];
  logic signed [31:0] rhs_mem [MAX_N];
  logic signed [31:0] guess_mem [2*MAX_N];
  logic signed [31:0] mat_q, rhs_q, guess_q;

  logic          mat_we, rhs_we, mat_re, rhs_re, guess_re, guess_we;
  logic [AW-1:0] mat_waddr, mat_raddr;
  logic [IW:0]   guess_raddr, guess_waddr;
  logic          load_ok, solve_go, div_start, out_free, sweep_cont;

  logic signed [31:0]      prev_val, sat_p;
  logic signed [63:0]      sh;
  logic signed [NUM_W-1:0] num;
  logic signed [32:0]      diff;
  logic [32:0]             diff_mag;

  jls_pkg::div_res_t div_res;

  jls_divider #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (diag),
    .res   (div_res)
  );

  always_comb begin
    if (size_in_use == 7'd0) begin
      n_m1_new = '0;
    end else if (32'(size_in_use) > MAX_N) begin
      n_m1_new = IW'(MAX_N - 1);
    end else begin
      n_m1_new = IW'(size_in_use - 7'd1);
    end
    load_ok    = (32'(row) < MAX_N) && (32'(col) < MAX_N);
    prev_val   = first ? 32'sd0 : guess_q;
    sh         = prod >>> 16;
    if (sh > P_MAX) begin
      sat_p = jls_pkg::Q_MAX;
    end else if (sh < P_MIN) begin
      sat_p = jls_pkg::Q_MIN;
    end else begin
      sat_p = sh[31:0];
    end
    num        = {{(NUM_W-32){rhs_q[31]}}, rhs_q} - {acc[ACC_W-1], acc};
    diff       = {x_reg[31], x_reg} - {prev_i[31], prev_i};
    diff_mag   = diff[32] ? 33'(-diff) : 33'(diff);
    out_free   = !out_valid || !out_stall;
    sweep_cont = (change_max >= {2'b00, tolerance}) && (left != 16'd1);
  end

  always_comb begin
    state_next = state;
    case (state)
      jls_pkg::ST_IDLE: begin
        if (solve_go) begin
          state_next = jls_pkg::ST_MAC;
        end
      end
      jls_pkg::ST_MAC: begin
        if (j_cnt == n_m1) begin
          state_next = jls_pkg::ST_DRAIN;
        end
      end
      jls_pkg::ST_DRAIN: begin
        if (!s1_v && !s2_v) begin
          state_next = jls_pkg::ST_DIV;
        end
      end
      jls_pkg::ST_DIV: begin
        if (div_res.done) begin
          state_next = jls_pkg::ST_WRITE;
        end
      end
      jls_pkg::ST_WRITE: begin
        state_next = (i_cnt == n_m1) ? jls_pkg::ST_SWEEP : jls_pkg::ST_MAC;
      end
      jls_pkg::ST_SWEEP: begin
        state_next = sweep_cont ? jls_pkg::ST_MAC : jls_pkg::ST_OUT_RD;
      end
      jls_pkg::ST_OUT_RD: begin
        state_next = jls_pkg::ST_OUT_LD;
      end
      jls_pkg::ST_OUT_LD: begin
        if (out_free) begin
          state_next = (i_cnt == n_m1) ? jls_pkg::ST_IDLE : jls_pkg::ST_OUT_RD;
        end
      end
      default: state_next = jls_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cfg_ready   = 1'b1;
    in_stall    = (state != jls_pkg::ST_IDLE);
    solve_go    = (state == jls_pkg::ST_IDLE) && in_valid && (command == jls_pkg::CMD_SOLVE);
    mat_we      = (state == jls_pkg::ST_IDLE) && in_valid && (command == jls_pkg::CMD_MAT)
                  && load_ok;
    rhs_we      = (state == jls_pkg::ST_IDLE) && in_valid && (command == jls_pkg::CMD_RHS)
                  && (32'(row) < MAX_N);
    mat_waddr   = AW'(row) * AW'(MAX_N) + AW'(col);
    mat_re      = (state == jls_pkg::ST_MAC);
    rhs_re      = (state == jls_pkg::ST_MAC);
    mat_raddr   = AW'(i_cnt) * AW'(MAX_N) + AW'(j_cnt);
    guess_re    = (state == jls_pkg::ST_MAC) || (state == jls_pkg::ST_OUT_RD);
    guess_raddr = (state == jls_pkg::ST_MAC) ? {bank, j_cnt} : {~bank, i_cnt};
    guess_we    = (state == jls_pkg::ST_WRITE);
    guess_waddr = {~bank, i_cnt};
    div_start   = (state == jls_pkg::ST_DRAIN) && !s1_v && !s2_v;
  end

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= value;
    end
    if (mat_re) begin
      mat_q <= mat_mem[mat_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rhs_we) begin
      rhs_mem[IW'(row)] <= value;
    end
    if (rhs_re) begin
      rhs_q <= rhs_mem[i_cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (guess_we) begin
      guess_mem[guess_waddr] <= x_reg;
    end
    if (guess_re) begin
      guess_q <= guess_mem[guess_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use    <= jls_pkg::SIZE_RST;
      tolerance      <= jls_pkg::TOL_RST;
      max_iterations <= jls_pkg::ITER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        jls_pkg::CFG_SIZE: size_in_use    <= cfg_data[6:0];
        jls_pkg::CFG_TOL:  tolerance      <= cfg_data[30:0];
        jls_pkg::CFG_ITER: max_iterations <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= jls_pkg::ST_IDLE;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      s1_v  <= (state == jls_pkg::ST_MAC);
      s2_v  <= s1_v && !s1_diag;
      if (state == jls_pkg::ST_OUT_LD && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_diag <= (j_cnt == i_cnt);
    if (s1_v) begin
      if (s1_diag) begin
        diag   <= mat_q;
        prev_i <= prev_val;
      end else begin
        prod <= mat_q * prev_val;
      end
    end
    if (state == jls_pkg::ST_MAC && j_cnt == '0) begin
      acc <= '0;
    end else if (s2_v) begin
      acc <= acc + {{(ACC_W-32){sat_p[31]}}, sat_p};
    end
    if (div_res.done) begin
      x_reg <= div_res.quot;
      if (div_res.zero_den) begin
        zero_flag <= 1'b1;
      end
    end
    case (state)
      jls_pkg::ST_IDLE: begin
        if (solve_go) begin
          n_m1        <= n_m1_new;
          i_cnt       <= '0;
          j_cnt       <= '0;
          first       <= 1'b1;
          bank        <= 1'b0;
          zero_flag   <= 1'b0;
          change_max  <= '0;
          sweep_count <= 16'd0;
          left        <= (max_iterations == 16'd0) ? 16'd1 : max_iterations;
        end
      end
      jls_pkg::ST_MAC: begin
        j_cnt <= (j_cnt == n_m1) ? '0 : j_cnt + IW'(1);
      end
      jls_pkg::ST_WRITE: begin
        if (diff_mag > change_max) begin
          change_max <= diff_mag;
        end
        if (i_cnt != n_m1) begin
          i_cnt <= i_cnt + IW'(1);
        end
      end
      jls_pkg::ST_SWEEP: begin
        sweep_count <= sweep_count + 16'd1;
        left        <= left - 16'd1;
        i_cnt       <= '0;
        if (sweep_cont) begin
          bank       <= ~bank;
          first      <= 1'b0;
          change_max <= '0;
        end else begin
          conv <= (change_max < {2'b00, tolerance});
        end
      end
      jls_pkg::ST_OUT_LD: begin
        if (out_free) begin
          index           <= 6'(i_cnt);
          solution        <= guess_q;
          converged       <= conv;
          iterations_used <= sweep_count;
          zero_pivot      <= zero_flag;
          last            <= (i_cnt == n_m1);
          if (i_cnt != n_m1) begin
            i_cnt <= i_cnt + IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/jls_checker.sv =====
// ----------------------------------------------------------------------------
// jls_checker
// Port-level checks on the Jacobi solver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module jls_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  command,
  input logic        out_valid,
  input logic        out_stall,
  input logic        last,
  input logic [15:0] iterations_used
);

  logic solve_taken;

  assign solve_taken = in_valid && !in_stall && (command == jls_pkg::CMD_SOLVE);

  `ASSERT_NEXT(a_solve_busy, clk, rst, solve_taken, in_stall, "solve item left input open")
  `ASSERT_IMPL(a_more_busy, clk, rst, out_valid && !last, in_stall, "input taken mid-run")
  `ASSERT_IMPL(a_iter_nonzero, clk, rst, out_valid, iterations_used != 16'd0, "zero sweeps")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "stalled item dropped")

endmodule

bind jacobi_linear_solver jls_checker u_jls_checker (.*);

`default_nettype wire
